/* rtl/core/assert_macros.svh */
// assertion helpers for the vertex transform block
// expects clk and rst in the scope where a macro is used

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define VAT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vat assertion failed");

// next-cycle implication, checked out of reset
`define VAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vat assertion failed");

`endif

/* rtl/core/vat_pkg.sv */
// shared types and constants for the vertex transform block
// no dependencies

package vat_pkg;

  localparam int COORD_W            = 32;
  localparam int CFG_W              = 64;
  localparam int CFG_IDX_W          = 3;
  localparam int NUM_REGS           = 6;
  localparam int FRAC_BITS_DEFAULT  = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int IN_DATA_W          = 3 * COORD_W;
  localparam int OUT_DATA_W         = 9 * COORD_W;

  // register reset values, 1.0 in q16.16 on the diagonal
  localparam logic [CFG_W-1:0] X_LIN_RESET  = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] X_REST_RESET = 64'h0000_0000_0000_0000;
  localparam logic [CFG_W-1:0] Y_LIN_RESET  = 64'h0001_0000_0000_0000;
  localparam logic [CFG_W-1:0] Y_REST_RESET = 64'h0000_0000_0000_0000;
  localparam logic [CFG_W-1:0] Z_LIN_RESET  = 64'h0000_0000_0000_0000;
  localparam logic [CFG_W-1:0] Z_REST_RESET = 64'h0000_0000_0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LIN  = 3'd0,
    REG_X_REST = 3'd1,
    REG_Y_LIN  = 3'd2,
    REG_Y_REST = 3'd3,
    REG_Z_LIN  = 3'd4,
    REG_Z_REST = 3'd5
  } vat_reg_idx_t;

  // one vertex as it waits in the queue
  typedef struct packed {
    logic                      last;
    logic                      seed;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vat_item_t;

  // one matrix row: three coefficients and a translation
  typedef struct packed {
    logic signed [COORD_W-1:0] tr;
    logic signed [COORD_W-1:0] cz;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cx;
  } vat_row_coef_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vat_q_status_t;

endpackage

/* rtl/core/vat_front.sv */
// front end: accepts vertex words and tags the one that seeds a new box
// depends on vat_pkg

module vat_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [vat_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  vat_pkg::vat_q_status_t        q_status,
  output logic                          push,
  output vat_pkg::vat_item_t            push_item,
  output logic                          set_pending
);

  localparam int W = vat_pkg::COORD_W;

  assign s_axis_tready = !q_status.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push_item.x    = s_axis_tdata[W-1:0];
    push_item.y    = s_axis_tdata[2*W-1:W];
    push_item.z    = s_axis_tdata[3*W-1:2*W];
    push_item.seed = set_pending;
    push_item.last = s_axis_tlast;
  end

  // the vertex after a last one opens a new set
  always_ff @(posedge clk) begin
    if (rst) begin
      set_pending <= 1'b1;
    end else if (push) begin
      set_pending <= s_axis_tlast;
    end
  end

endmodule

/* rtl/core/vat_queue.sv */
// short first-in first-out queue between front and back end
// depends on vat_pkg

module vat_queue #(
  parameter int DEPTH = vat_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  vat_pkg::vat_item_t     push_item,
  input  logic                   pop,
  output logic                   head_valid,
  output vat_pkg::vat_item_t     head_item,
  output vat_pkg::vat_q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vat_pkg::vat_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head_valid   = (count != '0);
  assign head_item    = mem[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/vat_row.sv */
// one output axis: products, sum, floor, translate and saturate over three stages
// depends on vat_pkg

module vat_row #(
  parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [vat_pkg::COORD_W-1:0] vx,
  input  logic signed [vat_pkg::COORD_W-1:0] vy,
  input  logic signed [vat_pkg::COORD_W-1:0] vz,
  input  vat_pkg::vat_row_coef_t             coef,
  output logic signed [vat_pkg::COORD_W-1:0] result
);

  localparam int W     = vat_pkg::COORD_W;
  localparam int P_W   = 2 * W;
  localparam int SUM_W = P_W + 1;
  localparam int SH_W  = SUM_W - FRAC_BITS;
  localparam int RES_W = SH_W + 1;

  logic signed [P_W-1:0]   p_x;
  logic signed [P_W-1:0]   p_y;
  logic signed [P_W-1:0]   p_z;
  logic signed [SUM_W-1:0] sum;
  logic signed [SH_W-1:0]  shifted;
  logic signed [RES_W-1:0] wide;
  logic [RES_W-W:0]        upper;
  logic signed [W-1:0]     sat;

  // dropping the fraction bits of the exact sum is the floor
  always_comb begin
    shifted = sum[SUM_W-1:FRAC_BITS];
    wide    = RES_W'(shifted) + RES_W'(coef.tr);
    upper   = wide[RES_W-1:W-1];
    if ((&upper) || !(|upper)) begin
      sat = wide[W-1:0];
    end else if (wide[RES_W-1]) begin
      sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x    <= vx * coef.cx;
      p_y    <= vy * coef.cy;
      p_z    <= vz * coef.cz;
      sum    <= SUM_W'(p_x) + SUM_W'(p_y) + SUM_W'(p_z);
      result <= sat;
    end
  end

endmodule

/* rtl/core/vat_back.sv */
// back end: pulls vertices from the queue, runs three row units, tracks the box
// depends on vat_pkg and vat_row

module vat_back #(
  parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  vat_pkg::vat_item_t             head_item,
  output logic                           pop,
  input  vat_pkg::vat_row_coef_t         coef_x,
  input  vat_pkg::vat_row_coef_t         coef_y,
  input  vat_pkg::vat_row_coef_t         coef_z,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [vat_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int W = vat_pkg::COORD_W;

  logic                adv;
  logic                v_p, v_s, v_r;
  logic                sd_p, sd_s, sd_r;
  logic                ls_p, ls_s, ls_r;
  logic signed [W-1:0] r_x, r_y, r_z;
  logic signed [W-1:0] o_x, o_y, o_z;
  logic signed [W-1:0] min_x, max_x, min_y, max_y, min_z, max_z;

  // whole pipe moves unless a finished word is held at the output
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign pop = head_valid && adv;

  vat_row #(.FRAC_BITS(FRAC_BITS)) u_row_x (
    .clk(clk), .adv(adv), .vx(head_item.x), .vy(head_item.y), .vz(head_item.z),
    .coef(coef_x), .result(r_x)
  );

  vat_row #(.FRAC_BITS(FRAC_BITS)) u_row_y (
    .clk(clk), .adv(adv), .vx(head_item.x), .vy(head_item.y), .vz(head_item.z),
    .coef(coef_y), .result(r_y)
  );

  vat_row #(.FRAC_BITS(FRAC_BITS)) u_row_z (
    .clk(clk), .adv(adv), .vx(head_item.x), .vy(head_item.y), .vz(head_item.z),
    .coef(coef_z), .result(r_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p           <= 1'b0;
      v_s           <= 1'b0;
      v_r           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v_p           <= pop;
      v_s           <= v_p;
      v_r           <= v_s;
      m_axis_tvalid <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_p         <= head_item.seed;
      ls_p         <= head_item.last;
      sd_s         <= sd_p;
      ls_s         <= ls_p;
      sd_r         <= sd_s;
      ls_r         <= ls_s;
      o_x          <= r_x;
      o_y          <= r_y;
      o_z          <= r_z;
      m_axis_tlast <= ls_r;
    end
  end

  // running box, updated as a vertex lands in the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= '0;
      max_x <= '0;
      min_y <= '0;
      max_y <= '0;
      min_z <= '0;
      max_z <= '0;
    end else if (adv && v_r) begin
      if (sd_r || r_x < min_x) min_x <= r_x;
      if (sd_r || r_x > max_x) max_x <= r_x;
      if (sd_r || r_y < min_y) min_y <= r_y;
      if (sd_r || r_y > max_y) max_y <= r_y;
      if (sd_r || r_z < min_z) min_z <= r_z;
      if (sd_r || r_z > max_z) max_z <= r_z;
    end
  end

  assign m_axis_tdata = {max_z, min_z, max_y, min_y, max_x, min_x, o_z, o_y, o_x};

endmodule

/* rtl/core/vertex_affine_transform_aabb.sv */
// top level of the affine vertex transform with running bounding box
// depends on vat_pkg, vat_front, vat_queue, vat_back and assert_macros.svh

// Transforms a stream of signed q16.16 vertices by the top three rows of an
// affine matrix (w taken as one) and tracks the axis-aligned bounding box of
// each set. Each row computes floor((cx*x + cy*y + cz*z) / 2^FRAC_BITS) + t
// from the exact product sum and saturates it to 32 bits. Every vertex gives
// one output word carrying the transformed vertex and the box so far; the
// word whose tlast is high carries the finished box, and the vertex after it
// seeds a new one. The block takes one vertex per clock sustained while the
// output is not stalled, set by the nine parallel 32x32 multipliers of the
// product stage. A vertex is written into the queue as it is taken, then
// passes the products, sum, saturate and output registers in that order.
// A QUEUE_DEPTH-entry queue (four by default) parts the input side from the
// arithmetic pipe, so either side can stall without stopping the other.
// Matrix registers are written through cfg_we / cfg_index / cfg_data and
// should only change while no vertex is in flight.

`include "assert_macros.svh"

module vertex_affine_transform_aabb #(
  parameter int FRAC_BITS   = vat_pkg::FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = vat_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // vertex in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // vertex_x, vertex_y, vertex_z
  input  logic [vat_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // last_vertex
  input  logic                           s_axis_tlast,
  // result out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_x, out_y, out_z, box_min_x, box_max_x, box_min_y, box_max_y,
  // box_min_z, box_max_z
  output logic [vat_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // box_done
  output logic                           m_axis_tlast,
  // matrix register writes
  input  logic                           cfg_we,
  input  logic [vat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vat_pkg::CFG_W-1:0]      cfg_data
);

  localparam int W = vat_pkg::COORD_W;

  logic [vat_pkg::CFG_W-1:0] cfg_regs [vat_pkg::NUM_REGS];

  vat_pkg::vat_row_coef_t coef_x, coef_y, coef_z;
  vat_pkg::vat_item_t     push_item, head_item;
  vat_pkg::vat_q_status_t q_status;
  logic                   push, pop, head_valid, set_pending;

  // matrix registers; writes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[vat_pkg::REG_X_LIN]  <= vat_pkg::X_LIN_RESET;
      cfg_regs[vat_pkg::REG_X_REST] <= vat_pkg::X_REST_RESET;
      cfg_regs[vat_pkg::REG_Y_LIN]  <= vat_pkg::Y_LIN_RESET;
      cfg_regs[vat_pkg::REG_Y_REST] <= vat_pkg::Y_REST_RESET;
      cfg_regs[vat_pkg::REG_Z_LIN]  <= vat_pkg::Z_LIN_RESET;
      cfg_regs[vat_pkg::REG_Z_REST] <= vat_pkg::Z_REST_RESET;
    end else if (cfg_we) begin
      unique case (vat_pkg::vat_reg_idx_t'(cfg_index))
        vat_pkg::REG_X_LIN:  cfg_regs[vat_pkg::REG_X_LIN]  <= cfg_data;
        vat_pkg::REG_X_REST: cfg_regs[vat_pkg::REG_X_REST] <= cfg_data;
        vat_pkg::REG_Y_LIN:  cfg_regs[vat_pkg::REG_Y_LIN]  <= cfg_data;
        vat_pkg::REG_Y_REST: cfg_regs[vat_pkg::REG_Y_REST] <= cfg_data;
        vat_pkg::REG_Z_LIN:  cfg_regs[vat_pkg::REG_Z_LIN]  <= cfg_data;
        vat_pkg::REG_Z_REST: cfg_regs[vat_pkg::REG_Z_REST] <= cfg_data;
        default: ;
      endcase
    end
  end

  // linear word: in x coefficient low, in y high; rest word: in z low, translation high
  always_comb begin
    coef_x.cx = cfg_regs[vat_pkg::REG_X_LIN][W-1:0];
    coef_x.cy = cfg_regs[vat_pkg::REG_X_LIN][2*W-1:W];
    coef_x.cz = cfg_regs[vat_pkg::REG_X_REST][W-1:0];
    coef_x.tr = cfg_regs[vat_pkg::REG_X_REST][2*W-1:W];
    coef_y.cx = cfg_regs[vat_pkg::REG_Y_LIN][W-1:0];
    coef_y.cy = cfg_regs[vat_pkg::REG_Y_LIN][2*W-1:W];
    coef_y.cz = cfg_regs[vat_pkg::REG_Y_REST][W-1:0];
    coef_y.tr = cfg_regs[vat_pkg::REG_Y_REST][2*W-1:W];
    coef_z.cx = cfg_regs[vat_pkg::REG_Z_LIN][W-1:0];
    coef_z.cy = cfg_regs[vat_pkg::REG_Z_LIN][2*W-1:W];
    coef_z.cz = cfg_regs[vat_pkg::REG_Z_REST][W-1:0];
    coef_z.tr = cfg_regs[vat_pkg::REG_Z_REST][2*W-1:W];
  end

  // front end: takes words, marks the seeding vertex
  vat_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item),
    .set_pending   (set_pending)
  );

  // decoupling queue
  vat_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .status     (q_status)
  );

  // arithmetic pipe, box tracking and output register
  vat_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .coef_x        (coef_x),
    .coef_y        (coef_y),
    .coef_z        (coef_z),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // box fields as seen on the output word
  logic signed [W-1:0] mon_min_x, mon_max_x, mon_min_y, mon_max_y, mon_min_z, mon_max_z;
  logic                box_ordered;

  assign mon_min_x = m_axis_tdata[4*W-1:3*W];
  assign mon_max_x = m_axis_tdata[5*W-1:4*W];
  assign mon_min_y = m_axis_tdata[6*W-1:5*W];
  assign mon_max_y = m_axis_tdata[7*W-1:6*W];
  assign mon_min_z = m_axis_tdata[8*W-1:7*W];
  assign mon_max_z = m_axis_tdata[9*W-1:8*W];

  assign box_ordered = (mon_min_x <= mon_max_x) && (mon_min_y <= mon_max_y) &&
                       (mon_min_z <= mon_max_z);

  // a shown box is never inverted on any axis
  `VAT_ASSERT_IMPL(a_box_order, m_axis_tvalid, box_ordered)

  // a last vertex taken arms the seed for the next one
  `VAT_ASSERT_NEXT(a_last_rearms, s_axis_tvalid && s_axis_tready && s_axis_tlast, set_pending)

  // a word taken in is held by the queue until the pipe pulls it
  `VAT_ASSERT_NEXT(a_push_lands, push, !q_status.empty)

endmodule
